FILE: hw/rtl/kdrs_pkg.sv
// shared types, constants and codes of the kernel density raster splat block
package kdrs_pkg;

  // raster geometry and walk limits
  localparam int RASTER_COLUMNS = 256;
  localparam int RASTER_ROWS    = 256;
  localparam int MAX_RADIUS     = 31;
  localparam int PIXEL_COUNT    = RASTER_COLUMNS * RASTER_ROWS;
  localparam int ADDR_W         = $clog2(PIXEL_COUNT);
  localparam int OFS_W          = 6;
  localparam int BB_W           = 2 * OFS_W;

  // arithmetic constants
  localparam int          Q16_ONE    = 65536;
  localparam int          KERNEL_MAX = 262143;
  localparam int          KERNEL_MIN = -262144;
  localparam logic [28:0] INV_PI_Q30 = 29'd341782638;

  // iterative unit lengths
  localparam int DIV_STEPS  = 43;
  localparam int SQRT_STEPS = 17;
  localparam int CNT_W      = 6;

  // item opcodes
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_e;

  // kernel shapes
  typedef enum logic [2:0] {
    SHAPE_TRI   = 3'd0,
    SHAPE_UNI   = 3'd1,
    SHAPE_QUART = 3'd2,
    SHAPE_TRIW  = 3'd3,
    SHAPE_EPAN  = 3'd4
  } shape_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SHAPE  = 2'd0,
    CFG_SCALED = 2'd1,
    CFG_DECAY  = 2'd2
  } cfg_idx_e;

  // input item
  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         column;
    logic [7:0]         row;
    logic [12:0]        radius_cells;
    logic signed [23:0] weight;
  } in_item_t;

  // result item
  typedef struct packed {
    logic signed [31:0] pixel_value;
    logic               is_no_data;
  } out_item_t;

  // datapath commands
  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_CLR_STEP,
    DP_SETUP,
    DP_POINT,
    DP_DIV_INIT,
    DP_SCALE_DIV_INIT,
    DP_DIV_STEP,
    DP_SQRT_INIT,
    DP_SQRT_STEP,
    DP_KERN_A,
    DP_KERN_B,
    DP_KERN_RAW,
    DP_SCALE_A,
    DP_SCALE_B,
    DP_SCALE_FIN,
    DP_CONTRIB,
    DP_RMW_RD,
    DP_RMW_WR,
    DP_ADVANCE,
    DP_READ_REQ,
    DP_READ_DONE
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       centre_ok;
    logic       skip_point;
    logic       walk_done;
    logic       quad_last;
    logic       clr_last;
    logic       need_scale;
  } dp_sts_t;

endpackage

FILE: hw/rtl/kdrs_ram.sv
// generic single write, single read ram with registered read data
module kdrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: hw/rtl/kdrs_datapath.sv
// datapath: item registers, kernel arithmetic units, raster memory and result
module kdrs_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kdrs_pkg::in_item_t  item_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [11:0]         cfg_data_i,
  input  kdrs_pkg::dp_cmd_t   cmd_i,
  output kdrs_pkg::dp_sts_t   sts_o,
  output kdrs_pkg::out_item_t result_o
);

  // configuration registers
  logic [2:0]         shape_q;
  logic               scaled_q;
  logic signed [11:0] decay_q;

  // latched item
  logic [1:0]         op_q;
  logic [7:0]         col_q, row_q;
  logic [12:0]        rad_q;
  logic signed [23:0] wt_q;

  // walk state
  logic [kdrs_pkg::OFS_W-1:0]  b_q, a_q, c_q;
  logic [kdrs_pkg::BB_W-1:0]   bb_q;
  logic [kdrs_pkg::OFS_W*2:0]  s_q;
  logic [1:0]                  quad_q;
  logic [22:0]                 dbb_q;

  // divider
  logic [23:0] rem_q;
  logic [42:0] quo_q;
  logic [22:0] dvs_q;

  // square root
  logic [33:0] sv_q;
  logic [20:0] srem_q;
  logic [16:0] root_q;
  logic [16:0] r2_q;

  // kernel
  logic [16:0]        u_q, uu_q;
  logic signed [31:0] tri_q;
  logic signed [18:0] k_q;
  logic [28:0]        kn_q;
  logic               ksign_q;
  logic [27:0]        x_q;
  logic signed [19:0] kf_q;
  logic signed [35:0] ctb_q;

  // clear sweep and result
  logic [kdrs_pkg::ADDR_W-1:0] clr_addr_q;
  logic                        pix_ok_q;
  kdrs_pkg::out_item_t         res_q;

  // memory port
  logic                        ram_we, ram_re;
  logic [kdrs_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [32:0]                 ram_wdata, ram_rdata;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q  <= kdrs_pkg::SHAPE_QUART;
      scaled_q <= 1'b0;
      decay_q  <= 12'sd256;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        kdrs_pkg::CFG_SHAPE:  shape_q  <= cfg_data_i[2:0];
        kdrs_pkg::CFG_SCALED: scaled_q <= cfg_data_i[0];
        kdrs_pkg::CFG_DECAY:  decay_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // offset arithmetic for the current walk point
  logic [kdrs_pkg::OFS_W*2:0] s_now;
  assign s_now = (kdrs_pkg::OFS_W*2+1)'(a_q) * (kdrs_pkg::OFS_W*2+1)'(a_q) +
                 (kdrs_pkg::OFS_W*2+1)'(c_q) * (kdrs_pkg::OFS_W*2+1)'(c_q);

  // current quadrant pixel
  logic signed [9:0] pr, pc;
  logic              pix_ok;
  logic [kdrs_pkg::ADDR_W-1:0] pix_addr;
  assign pr = quad_q[1] ? $signed({2'b00, row_q}) - $signed({4'b0000, a_q})
                        : $signed({2'b00, row_q}) + $signed({4'b0000, a_q});
  assign pc = quad_q[0] ? $signed({2'b00, col_q}) - $signed({4'b0000, c_q})
                        : $signed({2'b00, col_q}) + $signed({4'b0000, c_q});
  assign pix_ok = (pr >= 0) && (int'(pr) < kdrs_pkg::RASTER_ROWS) &&
                  (pc >= 0) && (int'(pc) < kdrs_pkg::RASTER_COLUMNS);
  assign pix_addr = kdrs_pkg::ADDR_W'(int'(pr) * kdrs_pkg::RASTER_COLUMNS + int'(pc));

  // read address of a read item
  logic                        rd_ok;
  logic [kdrs_pkg::ADDR_W-1:0] rd_addr;
  assign rd_ok   = (int'(col_q) < kdrs_pkg::RASTER_COLUMNS) &&
                   (int'(row_q) < kdrs_pkg::RASTER_ROWS);
  assign rd_addr = kdrs_pkg::ADDR_W'(int'(row_q) * kdrs_pkg::RASTER_COLUMNS + int'(col_q));

  // radius rounding and saturation
  logic [kdrs_pkg::OFS_W-1:0] b_round, b_sat;
  assign b_round = kdrs_pkg::OFS_W'(rad_q[12:8]) + kdrs_pkg::OFS_W'(rad_q[7:0] > 8'd128);
  assign b_sat   = (int'(b_round) > kdrs_pkg::MAX_RADIUS) ?
                   kdrs_pkg::OFS_W'(kdrs_pkg::MAX_RADIUS) : b_round;

  // normalizer denominator
  logic [12:0] den;
  assign den = (shape_q == kdrs_pkg::SHAPE_TRI) ?
               13'(13'sd256 + (13'(decay_q) <<< 1)) : 13'd1;

  // normalizer numerator
  logic [9:0] num;
  always_comb begin
    case (shape_q)
      kdrs_pkg::SHAPE_TRI:   num = 10'd768;
      kdrs_pkg::SHAPE_QUART: num = 10'd3;
      kdrs_pkg::SHAPE_TRIW:  num = 10'd4;
      kdrs_pkg::SHAPE_EPAN:  num = 10'd2;
      default:               num = 10'd1;
    endcase
  end

  // divider step
  logic [23:0] dtrial;
  logic        dge;
  assign dtrial = {rem_q[22:0], quo_q[42]};
  assign dge    = dtrial >= {1'b0, dvs_q};

  // square root step
  logic [20:0] strial, sshift;
  logic        sge;
  assign sshift = {srem_q[18:0], sv_q[33:32]};
  assign strial = {2'b00, root_q, 2'b01};
  assign sge    = sshift >= strial;

  // kernel first stage
  logic [16:0]        u_now;
  logic [33:0]        uu_full;
  logic signed [13:0] decay_comp;
  assign u_now      = (r2_q >= 17'(kdrs_pkg::Q16_ONE)) ? 17'd0
                                                        : 17'(kdrs_pkg::Q16_ONE) - r2_q;
  assign uu_full    = u_now * u_now;
  assign decay_comp = 14'sd256 - 14'(decay_q);

  // kernel second stage
  logic [33:0]        tw_full;
  logic signed [24:0] tri_k;
  logic signed [24:0] raw_k;
  logic signed [18:0] sat_k;
  assign tw_full = uu_q * u_q;
  assign tri_k   = 25'sd65536 - 25'(tri_q >>> 8);
  always_comb begin
    case (shape_q)
      kdrs_pkg::SHAPE_TRI:   raw_k = tri_k;
      kdrs_pkg::SHAPE_UNI:   raw_k = 25'sd65536;
      kdrs_pkg::SHAPE_QUART: raw_k = $signed({8'd0, uu_q});
      kdrs_pkg::SHAPE_TRIW:  raw_k = $signed({8'd0, tw_full[32:16]});
      kdrs_pkg::SHAPE_EPAN:  raw_k = $signed({8'd0, u_q});
      default:               raw_k = 25'sd0;
    endcase
    if (raw_k > 25'(kdrs_pkg::KERNEL_MAX)) begin
      sat_k = 19'(kdrs_pkg::KERNEL_MAX);
    end else if (raw_k < 25'(kdrs_pkg::KERNEL_MIN)) begin
      sat_k = 19'(kdrs_pkg::KERNEL_MIN);
    end else begin
      sat_k = 19'(raw_k);
    end
  end

  // scaling products
  logic [18:0] k_abs;
  logic [57:0] xpi;
  assign k_abs = k_q[18] ? 19'(-k_q) : 19'(k_q);
  assign xpi   = kn_q * kdrs_pkg::INV_PI_Q30;

  // contribution with centre and axis sharing
  logic signed [43:0] wk;
  logic signed [43:0] wk_sh;
  assign wk = wt_q * kf_q;
  always_comb begin
    if (a_q == '0 && c_q == '0) begin
      wk_sh = wk >>> 10;
    end else if (a_q == '0 || c_q == '0) begin
      wk_sh = wk >>> 9;
    end else begin
      wk_sh = wk >>> 8;
    end
  end

  // saturating pixel update
  logic signed [36:0] old_v, sum_v;
  logic signed [31:0] sum_sat;
  assign old_v = ram_rdata[32] ? 37'sd0 : 37'(signed'(ram_rdata[31:0]));
  assign sum_v = old_v + 37'(ctb_q);
  assign sum_sat = (sum_v > 37'sd2147483647)  ? 32'sh7fffffff :
                   (sum_v < -37'sd2147483648) ? 32'sh80000000 : 32'(sum_v);

  // memory port control
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = pix_addr;
    ram_raddr = pix_addr;
    ram_wdata = {1'b0, sum_sat};
    case (cmd_i.op)
      kdrs_pkg::DP_CLR_STEP: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
        ram_wdata = {1'b1, 32'd0};
      end
      kdrs_pkg::DP_RMW_RD:   ram_re = pix_ok;
      kdrs_pkg::DP_RMW_WR:   ram_we = pix_ok_q;
      kdrs_pkg::DP_READ_REQ: begin
        ram_re    = rd_ok;
        ram_raddr = rd_addr;
      end
      default: ;
    endcase
  end

  // control registers of the walk and sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q        <= '0;
      c_q        <= '0;
      quad_q     <= '0;
      clr_addr_q <= '0;
    end else begin
      case (cmd_i.op)
        kdrs_pkg::DP_CLR_STEP: begin
          if (int'(clr_addr_q) == kdrs_pkg::PIXEL_COUNT - 1) begin
            clr_addr_q <= '0;
          end else begin
            clr_addr_q <= clr_addr_q + 1'b1;
          end
        end
        kdrs_pkg::DP_RMW_WR: quad_q <= quad_q + 1'b1;
        kdrs_pkg::DP_ADVANCE: begin
          if (c_q == b_q) begin
            c_q <= '0;
            a_q <= (a_q == b_q) ? '0 : a_q + 1'b1;
          end else begin
            c_q <= c_q + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      kdrs_pkg::DP_LOAD: begin
        op_q  <= item_i.opcode;
        col_q <= item_i.column;
        row_q <= item_i.row;
        rad_q <= item_i.radius_cells;
        wt_q  <= item_i.weight;
        res_q <= '0;
      end
      kdrs_pkg::DP_SETUP: begin
        b_q  <= b_sat;
        bb_q <= (b_sat == '0) ? kdrs_pkg::BB_W'(1)
                              : kdrs_pkg::BB_W'(b_sat) * kdrs_pkg::BB_W'(b_sat);
      end
      kdrs_pkg::DP_POINT: begin
        s_q   <= s_now;
        dbb_q <= 23'(den) * 23'(bb_q);
      end
      kdrs_pkg::DP_DIV_INIT: begin
        quo_q <= {s_q[10:0], 32'd0};
        rem_q <= '0;
        dvs_q <= 23'(bb_q);
      end
      kdrs_pkg::DP_SCALE_DIV_INIT: begin
        quo_q <= 43'(x_q);
        rem_q <= '0;
        dvs_q <= dbb_q;
      end
      kdrs_pkg::DP_DIV_STEP: begin
        rem_q <= dge ? dtrial - {1'b0, dvs_q} : dtrial;
        quo_q <= {quo_q[41:0], dge};
      end
      kdrs_pkg::DP_SQRT_INIT: begin
        sv_q   <= quo_q[33:0];
        r2_q   <= quo_q[32:16];
        srem_q <= '0;
        root_q <= '0;
      end
      kdrs_pkg::DP_SQRT_STEP: begin
        srem_q <= sge ? sshift - strial : sshift;
        root_q <= {root_q[15:0], sge};
        sv_q   <= {sv_q[31:0], 2'b00};
      end
      kdrs_pkg::DP_KERN_A: begin
        u_q   <= u_now;
        uu_q  <= uu_full[32:16];
        tri_q <= decay_comp * $signed({1'b0, root_q});
      end
      kdrs_pkg::DP_KERN_B:   k_q  <= sat_k;
      kdrs_pkg::DP_KERN_RAW: kf_q <= 20'(k_q);
      kdrs_pkg::DP_SCALE_A: begin
        kn_q    <= 29'(k_abs) * 29'(num);
        ksign_q <= k_q[18];
      end
      kdrs_pkg::DP_SCALE_B:   x_q  <= xpi[57:30];
      kdrs_pkg::DP_SCALE_FIN: kf_q <= ksign_q ? -$signed(quo_q[19:0]) : $signed(quo_q[19:0]);
      kdrs_pkg::DP_CONTRIB:   ctb_q <= 36'(wk_sh);
      kdrs_pkg::DP_RMW_RD:    pix_ok_q <= pix_ok;
      kdrs_pkg::DP_READ_DONE: begin
        if (!rd_ok || ram_rdata[32]) begin
          res_q.pixel_value <= '0;
          res_q.is_no_data  <= 1'b1;
        end else begin
          res_q.pixel_value <= ram_rdata[31:0];
          res_q.is_no_data  <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  // raster store: density with a no-data mark on top
  kdrs_ram #(
    .WIDTH(33),
    .DEPTH(kdrs_pkg::PIXEL_COUNT)
  ) u_raster (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // status to the controller
  assign sts_o.opcode     = op_q;
  assign sts_o.centre_ok  = rd_ok;
  assign sts_o.skip_point = s_now > (kdrs_pkg::OFS_W*2+1)'(bb_q);
  assign sts_o.walk_done  = (a_q == b_q) && (c_q == b_q);
  assign sts_o.quad_last  = quad_q == 2'd3;
  assign sts_o.clr_last   = int'(clr_addr_q) == kdrs_pkg::PIXEL_COUNT - 1;
  assign sts_o.need_scale = scaled_q && (shape_q <= kdrs_pkg::SHAPE_EPAN) &&
                            !(shape_q == kdrs_pkg::SHAPE_TRI && decay_q < 0);

  assign result_o = res_q;

endmodule

FILE: hw/rtl/kdrs_ctrl.sv
// controller: sequences item decode, raster sweeps, the splat walk and results
module kdrs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  kdrs_pkg::dp_sts_t sts_i,
  output kdrs_pkg::dp_cmd_t cmd_o,
  output logic              busy_o,
  output logic              result_valid_o
);

  typedef enum logic [24:0] {
    ST_IDLE           = 25'h0000001,
    ST_INIT           = 25'h0000002,
    ST_DECODE         = 25'h0000004,
    ST_CLEAR          = 25'h0000008,
    ST_SETUP          = 25'h0000010,
    ST_POINT          = 25'h0000020,
    ST_DIV_INIT       = 25'h0000040,
    ST_DIV_RUN        = 25'h0000080,
    ST_SQRT_INIT      = 25'h0000100,
    ST_SQRT_RUN       = 25'h0000200,
    ST_KERN_A         = 25'h0000400,
    ST_KERN_B         = 25'h0000800,
    ST_KERN_RAW       = 25'h0001000,
    ST_SCALE_A        = 25'h0002000,
    ST_SCALE_B        = 25'h0004000,
    ST_SCALE_DIV_INIT = 25'h0008000,
    ST_SCALE_DIV_RUN  = 25'h0010000,
    ST_SCALE_FIN      = 25'h0020000,
    ST_CONTRIB        = 25'h0040000,
    ST_RMW_RD         = 25'h0080000,
    ST_RMW_WR         = 25'h0100000,
    ST_ADVANCE        = 25'h0200000,
    ST_READ_REQ       = 25'h0400000,
    ST_READ_DONE      = 25'h0800000,
    ST_RESULT         = 25'h1000000
  } state_e;

  state_e                     state_q, state_d;
  logic [kdrs_pkg::CNT_W-1:0] cnt_q, cnt_d;

  // next state and command
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmd_o.op  = kdrs_pkg::DP_NOP;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.op = kdrs_pkg::DP_LOAD;
          state_d  = ST_DECODE;
        end
      end
      ST_INIT: begin
        cmd_o.op = kdrs_pkg::DP_CLR_STEP;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_DECODE: begin
        unique case (sts_i.opcode)
          kdrs_pkg::OP_ADD:   state_d = ST_SETUP;
          kdrs_pkg::OP_READ:  state_d = ST_READ_REQ;
          kdrs_pkg::OP_CLEAR: state_d = ST_CLEAR;
          default:            state_d = ST_RESULT;
        endcase
      end
      ST_CLEAR: begin
        cmd_o.op = kdrs_pkg::DP_CLR_STEP;
        if (sts_i.clr_last) state_d = ST_RESULT;
      end
      ST_SETUP: begin
        cmd_o.op = kdrs_pkg::DP_SETUP;
        state_d  = sts_i.centre_ok ? ST_POINT : ST_RESULT;
      end
      ST_POINT: begin
        cmd_o.op = kdrs_pkg::DP_POINT;
        state_d  = sts_i.skip_point ? ST_ADVANCE : ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd_o.op = kdrs_pkg::DP_DIV_INIT;
        cnt_d    = '0;
        state_d  = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cmd_o.op = kdrs_pkg::DP_DIV_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == kdrs_pkg::CNT_W'(kdrs_pkg::DIV_STEPS - 1)) state_d = ST_SQRT_INIT;
      end
      ST_SQRT_INIT: begin
        cmd_o.op = kdrs_pkg::DP_SQRT_INIT;
        cnt_d    = '0;
        state_d  = ST_SQRT_RUN;
      end
      ST_SQRT_RUN: begin
        cmd_o.op = kdrs_pkg::DP_SQRT_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == kdrs_pkg::CNT_W'(kdrs_pkg::SQRT_STEPS - 1)) state_d = ST_KERN_A;
      end
      ST_KERN_A: begin
        cmd_o.op = kdrs_pkg::DP_KERN_A;
        state_d  = ST_KERN_B;
      end
      ST_KERN_B: begin
        cmd_o.op = kdrs_pkg::DP_KERN_B;
        state_d  = sts_i.need_scale ? ST_SCALE_A : ST_KERN_RAW;
      end
      ST_KERN_RAW: begin
        cmd_o.op = kdrs_pkg::DP_KERN_RAW;
        state_d  = ST_CONTRIB;
      end
      ST_SCALE_A: begin
        cmd_o.op = kdrs_pkg::DP_SCALE_A;
        state_d  = ST_SCALE_B;
      end
      ST_SCALE_B: begin
        cmd_o.op = kdrs_pkg::DP_SCALE_B;
        state_d  = ST_SCALE_DIV_INIT;
      end
      ST_SCALE_DIV_INIT: begin
        cmd_o.op = kdrs_pkg::DP_SCALE_DIV_INIT;
        cnt_d    = '0;
        state_d  = ST_SCALE_DIV_RUN;
      end
      ST_SCALE_DIV_RUN: begin
        cmd_o.op = kdrs_pkg::DP_DIV_STEP;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == kdrs_pkg::CNT_W'(kdrs_pkg::DIV_STEPS - 1)) state_d = ST_SCALE_FIN;
      end
      ST_SCALE_FIN: begin
        cmd_o.op = kdrs_pkg::DP_SCALE_FIN;
        state_d  = ST_CONTRIB;
      end
      ST_CONTRIB: begin
        cmd_o.op = kdrs_pkg::DP_CONTRIB;
        state_d  = ST_RMW_RD;
      end
      ST_RMW_RD: begin
        cmd_o.op = kdrs_pkg::DP_RMW_RD;
        state_d  = ST_RMW_WR;
      end
      ST_RMW_WR: begin
        cmd_o.op = kdrs_pkg::DP_RMW_WR;
        state_d  = sts_i.quad_last ? ST_ADVANCE : ST_RMW_RD;
      end
      ST_ADVANCE: begin
        cmd_o.op = kdrs_pkg::DP_ADVANCE;
        state_d  = sts_i.walk_done ? ST_RESULT : ST_POINT;
      end
      ST_READ_REQ: begin
        cmd_o.op = kdrs_pkg::DP_READ_REQ;
        state_d  = ST_READ_DONE;
      end
      ST_READ_DONE: begin
        cmd_o.op = kdrs_pkg::DP_READ_DONE;
        state_d  = ST_RESULT;
      end
      ST_RESULT: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // state registers, reset starts the mark sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o         = state_q != ST_IDLE;
  assign result_valid_o = state_q == ST_RESULT;

endmodule

FILE: hw/rtl/kernel_density_raster_splat_core.sv
// top level of the kernel density raster splat block
//
//   channel   direction  handshake                      payload
//   item      in         start high while busy low      item_i
//   result    out        result_valid_o for one cycle   result_o
//   config    in         cfg_valid_i and cfg_ready_o    cfg_index_i, cfg_data_i
//
// read item: a registered raster read, then its result; clear item: a sweep of all
// 65536 pixels; add item: per in-circle offset a 43-step division, 17-step root,
// kernel, for scaled shapes a second 43-step division, four read-modify-writes of
// the raster, over (b+1)^2 offsets; offsets outside the circle are skipped
// after reset a sweep marks every pixel no-data while busy is high; results cannot be
// stalled; config is always ready; user must write it only while idle, not enforced
module kernel_density_raster_splat_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  kdrs_pkg::in_item_t  item_i,
  output logic                result_valid_o,
  output kdrs_pkg::out_item_t result_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [11:0]         cfg_data_i
);

  kdrs_pkg::dp_cmd_t dp_cmd;
  kdrs_pkg::dp_sts_t dp_sts;

  assign cfg_ready_o = 1'b1;

  // sequencer
  kdrs_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .sts_i          (dp_sts),
    .cmd_o          (dp_cmd),
    .busy_o         (busy),
    .result_valid_o (result_valid_o)
  );

  // arithmetic and raster
  kdrs_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .result_o    (result_o)
  );

  // a result only comes while an item is in flight
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("result strobe while not busy");

  // an accepted item makes the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");

  // every raster write of a splat follows its read
  a_rmw_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_cmd.op == kdrs_pkg::DP_RMW_WR) |-> ($past(dp_cmd.op) == kdrs_pkg::DP_RMW_RD))
    else $error("pixel write without preceding read");

  // no item is loaded while the datapath is mid-walk
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dp_cmd.op == kdrs_pkg::DP_LOAD) |-> !busy) else $error("item loaded while busy");

endmodule
